// ===== rtl/ttc_pkg.sv =====
// Package: shared types, codes and constants of the timed trigger controller.
`timescale 1ns / 1ps
package ttc_pkg;

	localparam int unsigned CFG_COUNT = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESET_SMALL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESET_MEDIUM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESET_LARGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SMALL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_MEDIUM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LARGE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_MINIMUM = 3'd6;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_WAIT = 2'd1;
	localparam logic [1:0] MODE_ON = 2'd2;

	localparam logic [1:0] DIP_NONE = 2'd0;
	localparam logic [1:0] DIP_SMALL = 2'd1;
	localparam logic [1:0] DIP_MEDIUM = 2'd2;
	localparam logic [1:0] DIP_LARGE = 2'd3;

	localparam logic [2:0] CMD_UP = 3'd0;
	localparam logic [2:0] CMD_DOWN = 3'd1;
	localparam logic [2:0] CMD_RESET = 3'd2;
	localparam logic [2:0] CMD_DISABLE = 3'd3;
	localparam logic [2:0] CMD_FIRE = 3'd4;

	localparam logic [5:0] SEC_MAX = 6'd59;
	localparam logic [5:0] MIN_MAX = 6'd59;
	localparam logic [4:0] HOUR_MAX = 5'd23;
	localparam logic [7:0] TRIG_MAX = 8'hFF;
	localparam logic [7:0] TRIG_MIN = 8'h00;

	typedef struct packed {
		logic       half_second_tick;
		logic [1:0] dip_code;
		logic       button_down;
		logic       remote_valid;
		logic [2:0] remote_command;
		logic [9:0] battery_sample_a;
		logic [9:0] battery_sample_b;
		logic [9:0] battery_sample_c;
		logic [9:0] battery_sample_d;
	} in_item_t;

	typedef struct packed {
		logic       target_enable;
		logic [1:0] mode_now;
		logic       battery_low;
		logic [4:0] clock_hours;
		logic [5:0] clock_minutes;
		logic [5:0] clock_seconds;
		logic [7:0] trigger_minutes;
		logic       timer_off;
	} out_item_t;

	typedef struct packed {
		logic [7:0] preset_small;
		logic [7:0] preset_medium;
		logic [7:0] preset_large;
		logic [7:0] step_small;
		logic [7:0] step_medium;
		logic [7:0] step_large;
		logic [9:0] battery_minimum;
	} cfg_t;

endpackage

// ===== rtl/ttc_cfg_regs.sv =====
// Configuration register file of the timed trigger controller.
`timescale 1ns / 1ps
module ttc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [ttc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [ttc_pkg::CFG_DATA_W-1:0]  wr_data,
	output ttc_pkg::cfg_t                   cfg
);
	import ttc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preset_small <= 8'd5;
			cfg_q.preset_medium <= 8'd15;
			cfg_q.preset_large <= 8'd30;
			cfg_q.step_small <= 8'd1;
			cfg_q.step_medium <= 8'd5;
			cfg_q.step_large <= 8'd10;
			cfg_q.battery_minimum <= 10'd512;
		end else if (wr_en) begin
			case (wr_index)
				CFG_PRESET_SMALL: cfg_q.preset_small <= wr_data[7:0];
				CFG_PRESET_MEDIUM: cfg_q.preset_medium <= wr_data[7:0];
				CFG_PRESET_LARGE: cfg_q.preset_large <= wr_data[7:0];
				CFG_STEP_SMALL: cfg_q.step_small <= wr_data[7:0];
				CFG_STEP_MEDIUM: cfg_q.step_medium <= wr_data[7:0];
				CFG_STEP_LARGE: cfg_q.step_large <= wr_data[7:0];
				CFG_BATTERY_MINIMUM: cfg_q.battery_minimum <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ttc_core.sv =====
// Poll update: clock, trigger time, mode machine and battery check state.
`timescale 1ns / 1ps
module ttc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  ttc_pkg::in_item_t   item,
	input  ttc_pkg::cfg_t       cfg,
	output ttc_pkg::out_item_t  result
);
	import ttc_pkg::*;

	logic [1:0] mode_q, mode_n;
	logic       half_q, half_n;
	logic [5:0] sec_q, sec_n;
	logic [5:0] min_q, min_n;
	logic [4:0] hour_q, hour_n;
	logic [7:0] trig_q, trig_n;
	logic [1:0] dip_q, dip_n;
	logic       btn_q, btn_n;
	logic       pend_q, pend_n;
	logic       fire_q, fire_n;
	logic       tdis_q, tdis_n;
	logic       low_q, low_n;
	logic       en_q, en_n;

	function automatic logic [7:0] preset_for(input cfg_t c, input logic [1:0] dip);
		logic [7:0] v;
		case (dip)
			DIP_SMALL: v = c.preset_small;
			DIP_MEDIUM: v = c.preset_medium;
			DIP_LARGE: v = c.preset_large;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] step_for(input cfg_t c, input logic [1:0] dip);
		logic [7:0] v;
		case (dip)
			DIP_SMALL: v = c.step_small;
			DIP_MEDIUM: v = c.step_medium;
			DIP_LARGE: v = c.step_large;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	always_comb begin
		logic [11:0] sum;
		logic [9:0]  avg;
		logic [7:0]  st;
		logic [8:0]  up_sum;
		mode_n = mode_q;
		half_n = half_q;
		sec_n = sec_q;
		min_n = min_q;
		hour_n = hour_q;
		trig_n = trig_q;
		dip_n = dip_q;
		btn_n = btn_q;
		pend_n = pend_q;
		fire_n = fire_q;
		tdis_n = tdis_q;
		low_n = low_q;
		en_n = en_q;

		sum = {2'b00, item.battery_sample_a} + {2'b00, item.battery_sample_b}
			+ {2'b00, item.battery_sample_c} + {2'b00, item.battery_sample_d};
		avg = sum[11:2];

		// second advances on every other half-second tick
		if (item.half_second_tick) begin
			half_n = ~half_q;
			if (half_q) begin
				if (sec_q == SEC_MAX) begin
					sec_n = 6'd0;
					if (min_q == MIN_MAX) begin
						min_n = 6'd0;
						hour_n = (hour_q == HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
					end else begin
						min_n = min_q + 6'd1;
					end
				end else begin
					sec_n = sec_q + 6'd1;
				end
			end
		end

		if (item.dip_code != dip_q) begin
			trig_n = preset_for(cfg, item.dip_code);
		end
		dip_n = item.dip_code;
		if (item.button_down != btn_q) begin
			pend_n = 1'b1;
			btn_n = item.button_down;
		end

		st = step_for(cfg, dip_n);
		up_sum = {1'b0, trig_n} + {1'b0, st};
		if (item.remote_valid) begin
			case (item.remote_command)
				CMD_UP: trig_n = up_sum[8] ? TRIG_MAX : up_sum[7:0];
				CMD_DOWN: trig_n = (st > trig_n) ? TRIG_MIN : trig_n - st;
				CMD_RESET: begin
					sec_n = 6'd0;
					min_n = 6'd0;
					hour_n = 5'd0;
					tdis_n = 1'b0;
				end
				CMD_DISABLE: tdis_n = 1'b1;
				CMD_FIRE: fire_n = 1'b1;
				default: ;
			endcase
		end

		case (mode_q)
			MODE_WAIT: begin
				if ((pend_n && btn_n) || fire_n) begin
					mode_n = MODE_ON;
					pend_n = 1'b0;
					fire_n = 1'b0;
				end else if (!tdis_n && dip_n != DIP_NONE && {2'b00, min_n} >= trig_n) begin
					mode_n = MODE_ON;
				end
			end
			MODE_ON: begin
				if ((pend_n && btn_n) || fire_n || low_q) begin
					mode_n = MODE_START;
					pend_n = 1'b0;
					fire_n = 1'b0;
				end
			end
			default: begin
				sec_n = 6'd0;
				min_n = 6'd0;
				hour_n = 5'd0;
				trig_n = preset_for(cfg, dip_n);
				mode_n = MODE_WAIT;
			end
		endcase

		case (mode_n)
			MODE_WAIT: en_n = 1'b0;
			MODE_ON: begin
				if (avg >= cfg.battery_minimum) begin
					en_n = 1'b1;
					low_n = 1'b0;
				end else begin
					low_n = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			half_q <= 1'b0;
			sec_q <= 6'd0;
			min_q <= 6'd0;
			hour_q <= 5'd0;
			trig_q <= 8'd0;
			dip_q <= DIP_NONE;
			btn_q <= 1'b0;
			pend_q <= 1'b0;
			fire_q <= 1'b0;
			tdis_q <= 1'b0;
			low_q <= 1'b0;
			en_q <= 1'b0;
		end else if (step_en) begin
			mode_q <= mode_n;
			half_q <= half_n;
			sec_q <= sec_n;
			min_q <= min_n;
			hour_q <= hour_n;
			trig_q <= trig_n;
			dip_q <= dip_n;
			btn_q <= btn_n;
			pend_q <= pend_n;
			fire_q <= fire_n;
			tdis_q <= tdis_n;
			low_q <= low_n;
			en_q <= en_n;
		end
	end

	// the result item is the updated state itself
	assign result.target_enable = en_q;
	assign result.mode_now = mode_q;
	assign result.battery_low = low_q;
	assign result.clock_hours = hour_q;
	assign result.clock_minutes = min_q;
	assign result.clock_seconds = sec_q;
	assign result.trigger_minutes = trig_q;
	assign result.timer_off = tdis_q;

`ifndef SYNTHESIS
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= MODE_ON)
		else $error("unused mode code reached");
	a_wait_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_WAIT |-> !en_q)
		else $error("target enabled while waiting");
	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q <= SEC_MAX && min_q <= MIN_MAX && hour_q <= HOUR_MAX)
		else $error("clock out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(mode_q) && $stable(trig_q) && $stable(sec_q))
		else $error("state moved without an item");
`endif

endmodule

// ===== rtl/timed_trigger_controller.sv =====
// Top level of the timed trigger controller: handshakes, input stage and result stage.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_item): one poll per cycle unless stalled.
//  - Result channel (out_valid/out_ready/out_item) gives exactly one item per poll:
//    the enable, mode, battery, clock, trigger and timer state after that poll.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes register
//    cfg_index; cfg_ready is always high, indexes past the last register are ignored.
//    Write configuration only while no poll is in flight.
//  - Timing: an accepted item is registered in the input stage, then its result
//    is registered in the state registers and shown from then on.
//  - Throughput: one item per cycle while the receiver is ready, set by the single
//    update of the state registers, which are also the result register.
//  - Receiver stall: the result holds, the input stage keeps one more item,
//    then in_ready drops until out_ready returns.
//  - Reset (arst_n low): clock, trigger time and flags clear, mode is start-up,
//    configuration returns to its defaults, both stages empty.
`timescale 1ns / 1ps
module timed_trigger_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ttc_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ttc_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ttc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ttc_pkg::*;

	in_item_t in_item_s1;
	logic     valid_s1;
	logic     out_valid_q;
	logic     advance;
	cfg_t     cfg;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_item_s1 <= in_item;
		end
	end

	ttc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ttc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (in_item_s1),
		.cfg     (cfg),
		.result  (out_item)
	);

`ifndef SYNTHESIS
	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result not shown after update");
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(in_item_s1))
		else $error("input stage lost an item");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("result overwritten while stalled");
`endif

endmodule

// ===== tb/timed_trigger_controller_tb.sv =====
// Testbench for timed_trigger_controller: directed poll table, then random polls checked live.
`timescale 1ns / 1ps
module timed_trigger_controller_tb;
	import ttc_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 7;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam int POLLS_PER_PHASE = 232;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
	localparam logic [2:0] CMD_MENU = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	typedef struct {
		bit                     is_write;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [CFG_DATA_W-1:0]  reg_value;
		in_item_t               poll;
		bit                     typed;
		out_item_t              want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	cfg_t cfg_q;
	logic [1:0] mode_q;
	logic half_q;
	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hr_q;
	logic [7:0] trig_q;
	logic [1:0] dip_q;
	logic btn_q;
	logic btn_evt_q;
	logic fire_q;
	logic timer_off_q;
	logic low_q;
	logic en_q;

	out_item_t status_due[$];
	bit steady_stretch = 1'b0;
	logic [1:0] stim_dip = DIP_NONE;
	logic stim_btn = 1'b0;
	int polls_sent = 0;
	int status_checked = 0;
	int mismatches = 0;

	timed_trigger_controller DUT (.*);

	always #HALF_PERIOD clk = ~clk;

	function automatic void zero_clock();
		sec_q = '0;
		min_q = '0;
		hr_q = '0;
	endfunction

	function automatic logic [7:0] preset_of(logic [1:0] dip);
		case (dip)
			DIP_SMALL: return cfg_q.preset_small;
			DIP_MEDIUM: return cfg_q.preset_medium;
			DIP_LARGE: return cfg_q.preset_large;
			default: return TRIG_MIN;
		endcase
	endfunction

	function automatic void reset_controller();
		cfg_q = '{8'd5, 8'd15, 8'd30, 8'd1, 8'd5, 8'd10, 10'd512};
		mode_q = MODE_START;
		half_q = 1'b0;
		zero_clock();
		trig_q = '0;
		dip_q = DIP_NONE;
		btn_q = 1'b0;
		btn_evt_q = 1'b0;
		fire_q = 1'b0;
		timer_off_q = 1'b0;
		low_q = 1'b0;
		en_q = 1'b0;
	endfunction

	function automatic out_item_t poll_controller(in_item_t p);
		logic [11:0] sum;
		logic [9:0] avg;
		logic [7:0] stp;
		logic [8:0] up;
		sum = 12'(p.battery_sample_a) + 12'(p.battery_sample_b)
			+ 12'(p.battery_sample_c) + 12'(p.battery_sample_d);
		avg = sum[11:2];
		if (p.half_second_tick) begin
			half_q = ~half_q;
			if (!half_q) begin
				if (sec_q == SEC_MAX) begin
					sec_q = '0;
					if (min_q == MIN_MAX) begin
						min_q = '0;
						hr_q = (hr_q == HOUR_MAX) ? '0 : hr_q + 5'd1;
					end else begin
						min_q = min_q + 6'd1;
					end
				end else begin
					sec_q = sec_q + 6'd1;
				end
			end
		end
		if (p.dip_code != dip_q)
			trig_q = preset_of(p.dip_code);
		dip_q = p.dip_code;
		if (p.button_down != btn_q) begin
			btn_evt_q = 1'b1;
			btn_q = p.button_down;
		end
		if (p.remote_valid) begin
			case (dip_q)
				DIP_SMALL: stp = cfg_q.step_small;
				DIP_MEDIUM: stp = cfg_q.step_medium;
				DIP_LARGE: stp = cfg_q.step_large;
				default: stp = '0;
			endcase
			case (p.remote_command)
				CMD_UP: begin
					up = 9'(trig_q) + 9'(stp);
					trig_q = up[8] ? TRIG_MAX : up[7:0];
				end
				CMD_DOWN: trig_q = (stp > trig_q) ? TRIG_MIN : trig_q - stp;
				CMD_RESET: begin
					zero_clock();
					timer_off_q = 1'b0;
				end
				CMD_DISABLE: timer_off_q = 1'b1;
				CMD_FIRE: fire_q = 1'b1;
				default: ;
			endcase
		end
		case (mode_q)
			MODE_WAIT: begin
				if ((btn_evt_q && btn_q) || fire_q) begin
					mode_q = MODE_ON;
					btn_evt_q = 1'b0;
					fire_q = 1'b0;
				end else if (!timer_off_q && dip_q != DIP_NONE && 8'(min_q) >= trig_q) begin
					mode_q = MODE_ON;
				end
			end
			MODE_ON: begin
				if ((btn_evt_q && btn_q) || fire_q || low_q) begin
					mode_q = MODE_START;
					btn_evt_q = 1'b0;
					fire_q = 1'b0;
				end
			end
			default: begin
				zero_clock();
				trig_q = preset_of(dip_q);
				mode_q = MODE_WAIT;
			end
		endcase
		if (mode_q == MODE_WAIT) begin
			en_q = 1'b0;
		end else if (mode_q == MODE_ON) begin
			if (avg >= cfg_q.battery_minimum) begin
				en_q = 1'b1;
				low_q = 1'b0;
			end else begin
				low_q = 1'b1;
			end
		end
		return '{en_q, mode_q, low_q, hr_q, min_q, sec_q, trig_q, timer_off_q};
	endfunction

	function automatic int draw_gap();
		return steady_stretch ? 0 : int'($urandom_range(0, 6));
	endfunction

	function automatic in_item_t mk_poll(bit tick, logic [1:0] dip, bit btn, bit rv,
		logic [2:0] cmd, int a, int b, int c, int d);
		return '{tick, dip, btn, rv, cmd, 10'(a), 10'(b), 10'(c), 10'(d)};
	endfunction

	function automatic in_item_t random_poll();
		in_item_t p;
		logic [63:0] raw;
		int lvl;
		int v;
		logic [9:0] s[4];
		if ($urandom_range(0, 15) == 0) begin
			raw = {$urandom(), $urandom()};
			return raw[$bits(in_item_t)-1:0];
		end
		if ($urandom_range(0, 15) == 0)
			stim_dip = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0)
			stim_btn = ~stim_btn;
		p.half_second_tick = ($urandom_range(0, 3) != 0);
		p.dip_code = stim_dip;
		p.button_down = stim_btn;
		p.remote_valid = ($urandom_range(0, 3) == 0);
		p.remote_command = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		if ($urandom_range(0, 3) == 0) begin
			for (int k = 0; k < 4; k++)
				s[k] = 10'($urandom_range(0, 1023));
		end else begin
			lvl = int'(cfg_q.battery_minimum) + int'($urandom_range(0, 16)) - 8;
			for (int k = 0; k < 4; k++) begin
				v = lvl + int'($urandom_range(0, 6)) - 3;
				s[k] = (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : 10'(v);
			end
		end
		p.battery_sample_a = s[0];
		p.battery_sample_b = s[1];
		p.battery_sample_c = s[2];
		p.battery_sample_d = s[3];
		return p;
	endfunction

	task automatic send_poll(in_item_t p, bit typed, out_item_t want);
		int gap;
		out_item_t predicted;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= p;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = poll_controller(p);
		status_due.push_back(typed ? want : predicted);
		polls_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_PRESET_SMALL: cfg_q.preset_small = val[7:0];
			CFG_PRESET_MEDIUM: cfg_q.preset_medium = val[7:0];
			CFG_PRESET_LARGE: cfg_q.preset_large = val[7:0];
			CFG_STEP_SMALL: cfg_q.step_small = val[7:0];
			CFG_STEP_MEDIUM: cfg_q.step_medium = val[7:0];
			CFG_STEP_LARGE: cfg_q.step_large = val[7:0];
			CFG_BATTERY_MINIMUM: cfg_q.battery_minimum = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	initial begin : status_sink
		int stall;
		bit held;
		out_item_t want;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap();
			if (!held && status_checked == HOLD_AT) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			status_checked++;
			if (status_due.size() == 0) begin
				$error("status item with nothing expected: %h", out_item);
				mismatches++;
			end else begin
				want = status_due.pop_front();
				check_field("target_enable", 32'(want.target_enable),
					32'(out_item.target_enable));
				check_field("mode_now", 32'(want.mode_now), 32'(out_item.mode_now));
				check_field("battery_low", 32'(want.battery_low), 32'(out_item.battery_low));
				check_field("clock_hours", 32'(want.clock_hours), 32'(out_item.clock_hours));
				check_field("clock_minutes", 32'(want.clock_minutes),
					32'(out_item.clock_minutes));
				check_field("clock_seconds", 32'(want.clock_seconds),
					32'(out_item.clock_seconds));
				check_field("trigger_minutes", 32'(want.trigger_minutes),
					32'(out_item.trigger_minutes));
				check_field("timer_off", 32'(want.timer_off), 32'(out_item.timer_off));
			end
		end
	end

	initial begin : stimulus
		script_row_t script[$];
		int directed_polls;
		int settings_used;
		logic [CFG_DATA_W-1:0] val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_controller();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default registers first
		script.push_back('{0, '0, '0, mk_poll(0, DIP_NONE, 0, 0, CMD_UP, 0, 0, 0, 0), 1,
			'{1'b0, MODE_WAIT, 1'b0, 5'd0, 6'd0, 6'd0, 8'd0, 1'b0}});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_LARGE, 0, 1, CMD_UP, 600, 600, 600, 600), 1,
			'{1'b0, MODE_WAIT, 1'b0, 5'd0, 6'd0, 6'd0, 8'd40, 1'b0}});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_LARGE, 0, 1, CMD_DOWN, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_NONE, 0, 1, CMD_UP, 600, 600, 600, 600), 1,
			'{1'b0, MODE_WAIT, 1'b0, 5'd0, 6'd0, 6'd0, 8'd0, 1'b0}});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_NONE, 0, 1, CMD_DOWN, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(1, DIP_MEDIUM, 0, 1, CMD_DISABLE, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(1, DIP_MEDIUM, 0, 0, CMD_FIRE, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(1, DIP_MEDIUM, 0, 1, CMD_MENU, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(1, DIP_MEDIUM, 0, 1, CMD_RSVD6, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(1, DIP_MEDIUM, 0, 1, CMD_RSVD7, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(1, DIP_MEDIUM, 0, 1, CMD_RESET, 600, 600, 600, 600),
			0, '0});
		// button press turns on, release with flat battery, then drop back to start-up
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 1, 0, CMD_UP, 1023, 1023, 1023, 1023),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 1, 0, CMD_UP, 1023, 1023, 1023, 1023),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 0, 0, CMD_UP, 0, 0, 0, 0), 0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 0, 0, CMD_UP, 1023, 1023, 1023, 1023),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 0, 0, CMD_UP, 600, 600, 600, 600),
			0, '0});
		// average exactly at the minimum, then one below
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 0, 1, CMD_FIRE, 511, 512, 512, 513),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 0, 0, CMD_UP, 511, 511, 511, 511),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 0, 0, CMD_UP, 600, 600, 600, 600),
			0, '0});
		// top saturation, a step down to exactly zero; out-of-range register index is dropped
		script.push_back('{1, CFG_STEP_LARGE, 10'd255, '0, 0, '0});
		script.push_back('{1, CFG_IDX_UNUSED, 10'h3FF, '0, 0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_MEDIUM, 0, 0, CMD_UP, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_LARGE, 0, 1, CMD_UP, 600, 600, 600, 600),
			0, '0});
		script.push_back('{0, '0, '0, mk_poll(0, DIP_LARGE, 0, 1, CMD_DOWN, 600, 600, 600, 600),
			0, '0});

		foreach (script[i]) begin
			if (script[i].is_write) begin
				drain();
				write_register(script[i].reg_index, script[i].reg_value);
			end else begin
				send_poll(script[i].poll, script[i].typed, script[i].want);
			end
		end
		directed_polls = polls_sent;
		settings_used = 2;

		// phases: small random, all zero, all ones, fully random
		for (int phase = 0; phase < 4; phase++) begin
			drain();
			for (int r = 0; r < CFG_COUNT; r++) begin
				case (phase)
					0: begin
						if (r == int'(CFG_BATTERY_MINIMUM))
							val = 10'($urandom_range(300, 700));
						else if (r < int'(CFG_STEP_SMALL))
							val = 10'($urandom_range(0, 3));
						else
							val = 10'($urandom_range(0, 15));
					end
					1: val = '0;
					2: val = '1;
					default: val = 10'($urandom_range(0, 1023));
				endcase
				write_register(CFG_IDX_W'(r), val);
			end
			settings_used++;
			steady_stretch = (phase == 1);
			repeat (POLLS_PER_PHASE)
				send_poll(random_poll(), 1'b0, '0);
		end
		steady_stretch = 1'b0;
		drain();

		$display("Covered %0d polls (%0d from the directed table) over %0d register settings.",
			polls_sent, directed_polls, settings_used);
		$display("%0d status items checked, including a %0d-cycle receiver hold-off.",
			status_checked, HOLD_CYCLES);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timed out with %0d status items outstanding.", status_due.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
